>>> rtl/core/srl_pkg.sv
// Shared types and constants for the S-record loader.
package srl_pkg;

  localparam int unsigned SRL_QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_S    = 8'h53;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_ONE  = 8'h31;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_UC_A = 8'h41;
  localparam logic [7:0] CHAR_UC_F = 8'h46;
  localparam logic [7:0] CHAR_LC_A = 8'h61;
  localparam logic [7:0] CHAR_LC_F = 8'h66;
  localparam logic [7:0] MIN_COUNT = 8'd3;

  typedef enum logic [2:0] {
    PH_WAIT    = 3'd0,
    PH_TYPE    = 3'd1,
    PH_COUNT   = 3'd2,
    PH_ADDR_HI = 3'd3,
    PH_ADDR_LO = 3'd4,
    PH_BODY    = 3'd5,
    PH_TAIL    = 3'd6,
    PH_SKIP    = 3'd7
  } srl_phase_e;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_NOT_S = 3'd1,
    ERR_TYPE  = 3'd2,
    ERR_SUM   = 3'd3,
    ERR_HEX   = 3'd4
  } srl_err_e;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_START = 2'd1,
    KIND_OK    = 2'd2,
    KIND_ERROR = 2'd3
  } srl_kind_e;

  typedef enum logic [1:0] {
    RT_S0 = 2'd0,
    RT_S1 = 2'd1,
    RT_S9 = 2'd2
  } srl_rtype_e;

  // One classified character as it travels from front to back.
  typedef struct packed {
    logic       is_lf;
    logic       is_s;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       type_ok;
    logic [1:0] type_code;
  } srl_item_t;

endpackage

>>> rtl/core/srecord_loader_unit.sv
// Top level of the S-record loader: front end, queue and record engine.
//
//  channel   | dir | signals                            | contents
//  s_axis    | in  | tvalid tready tdata[7:0]           | one text character
//  m_axis    | out | tvalid tready tdata[31:0] tuser[1:0]| write, start, ok or error
//  cfg       | in  | cfg_we_i cfg_wdata_i               | checksum check enable
//
// One character per cycle while the queue is not full; a result leaves through the
// queue and the result register of the record engine.
// Carriage returns are dropped in the front end and never reach the queue.
// Reset clears the record state and sets checksum checking on.
// A stalled m_axis holds the engine; s_axis keeps taking characters until
// the QUEUE_DEPTH-entry queue is full.
module srecord_loader_unit #(
  parameter int unsigned QUEUE_DEPTH = srl_pkg::SRL_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [15:0] address, [23:16] data, [26:24] error_code
  output logic [1:0]  m_axis_tuser_o    // [1:0] kind
);
  import srl_pkg::*;

  srl_item_t push_item, pop_item;
  logic      push, q_full, q_valid, pop;

  srl_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tready_o (s_axis_tready_o),
    .q_full_i        (q_full),
    .push_o          (push),
    .item_o          (push_item)
  );

  srl_queue #(
    .WIDTH ($bits(srl_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_item)
  );

  srl_exec u_exec (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .q_valid_i       (q_valid),
    .item_i          (pop_item),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

>>> rtl/core/srl_front.sv
// Front end: takes characters, drops carriage returns, classifies the rest.
module srl_front (
  input  logic              s_axis_tvalid_i,
  input  logic [7:0]        s_axis_tdata_i,
  output logic              s_axis_tready_o,
  input  logic              q_full_i,
  output logic              push_o,
  output srl_pkg::srl_item_t item_o
);
  import srl_pkg::*;

  logic [7:0] c;
  logic       is_cr;

  assign c     = s_axis_tdata_i;
  assign is_cr = (c == CHAR_CR);

  assign s_axis_tready_o = !q_full_i;
  assign push_o          = s_axis_tvalid_i && !q_full_i && !is_cr;

  always_comb begin
    item_o.is_lf     = (c == CHAR_LF);
    item_o.is_s      = (c == CHAR_S);
    item_o.hex_ok    = 1'b0;
    item_o.hex_val   = 4'd0;
    item_o.type_ok   = 1'b1;
    item_o.type_code = RT_S0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      item_o.hex_ok  = 1'b1;
      item_o.hex_val = 4'(c - CHAR_ZERO);
    end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
      item_o.hex_ok  = 1'b1;
      item_o.hex_val = 4'(c - CHAR_UC_A + 8'd10);
    end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
      item_o.hex_ok  = 1'b1;
      item_o.hex_val = 4'(c - CHAR_LC_A + 8'd10);
    end
    if (c == CHAR_ZERO) begin
      item_o.type_code = RT_S0;
    end else if (c == CHAR_ONE) begin
      item_o.type_code = RT_S1;
    end else if (c == CHAR_NINE) begin
      item_o.type_code = RT_S9;
    end else begin
      item_o.type_ok = 1'b0;
    end
  end

endmodule

>>> rtl/core/srl_queue.sv
// Small register queue between the front end and the record engine.
module srl_queue #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/core/srl_exec.sv
// Record engine: walks the record fields and drives the result register.
module srl_exec (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               q_valid_i,
  input  srl_pkg::srl_item_t item_i,
  output logic               pop_o,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [31:0]        m_axis_tdata_o,
  output logic [1:0]         m_axis_tuser_o
);
  import srl_pkg::*;

  srl_phase_e phase_q, phase_d;
  srl_rtype_e rtype_q, rtype_d;
  srl_err_e   err_q, err_d;
  logic [3:0]  high_q, high_d;
  logic        pend_q, pend_d;
  logic [7:0]  left_q, left_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  sum_q, sum_d;
  logic        chk_en_q;

  logic        out_valid_q;
  srl_kind_e   out_kind_q, kind_c;
  logic [15:0] out_addr_q, oaddr_c;
  logic [7:0]  out_data_q, odata_c;
  srl_err_e    out_err_q, oerr_c;

  logic       emit_c;
  logic       fail_c;
  srl_err_e   fail_code;
  srl_err_e   lf_err;
  logic [7:0] byte_c;
  logic       out_free;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign pop_o    = q_valid_i && out_free;
  assign byte_c   = {high_q, item_i.hex_val};

  always_comb begin
    phase_d   = phase_q;
    rtype_d   = rtype_q;
    err_d     = err_q;
    high_d    = high_q;
    pend_d    = pend_q;
    left_d    = left_q;
    addr_d    = addr_q;
    sum_d     = sum_q;
    emit_c    = 1'b0;
    kind_c    = KIND_OK;
    oaddr_c   = '0;
    odata_c   = '0;
    oerr_c    = ERR_NONE;
    fail_c    = 1'b0;
    fail_code = ERR_NONE;
    lf_err    = err_q;
    if (item_i.is_lf) begin
      if (phase_q != PH_WAIT) begin
        if (err_q == ERR_NONE) begin
          if (phase_q == PH_TYPE) begin
            lf_err = ERR_TYPE;
          end else if (phase_q != PH_TAIL && phase_q != PH_SKIP) begin
            lf_err = ERR_HEX;
          end
        end
        emit_c = 1'b1;
        if (lf_err != ERR_NONE) begin
          kind_c = KIND_ERROR;
          oerr_c = lf_err;
        end else if (rtype_q == RT_S9) begin
          kind_c  = KIND_START;
          oaddr_c = addr_q;
        end
        // end of record: keep address and type, clear the rest
        phase_d = PH_WAIT;
        high_d  = '0;
        pend_d  = 1'b0;
        left_d  = '0;
        sum_d   = '0;
        err_d   = ERR_NONE;
      end
    end else begin
      unique case (phase_q)
        PH_WAIT: begin
          if (item_i.is_s) begin
            phase_d = PH_TYPE;
          end else begin
            fail_c    = 1'b1;
            fail_code = ERR_NOT_S;
          end
        end
        PH_TYPE: begin
          if (item_i.type_ok) begin
            rtype_d = srl_rtype_e'(item_i.type_code);
            phase_d = PH_COUNT;
            pend_d  = 1'b0;
          end else begin
            fail_c    = 1'b1;
            fail_code = ERR_TYPE;
          end
        end
        PH_TAIL, PH_SKIP: begin
        end
        default: begin
          if (!item_i.hex_ok) begin
            fail_c    = 1'b1;
            fail_code = ERR_HEX;
          end else if (!pend_q) begin
            high_d = item_i.hex_val;
            pend_d = 1'b1;
          end else begin
            pend_d = 1'b0;
            unique case (phase_q)
              PH_COUNT: begin
                if (byte_c < MIN_COUNT) begin
                  fail_c    = 1'b1;
                  fail_code = ERR_HEX;
                end else begin
                  sum_d   = byte_c;
                  left_d  = byte_c - 8'd2;
                  phase_d = PH_ADDR_HI;
                end
              end
              PH_ADDR_HI: begin
                sum_d   = sum_q + byte_c;
                addr_d  = {byte_c, 8'h00};
                phase_d = PH_ADDR_LO;
              end
              PH_ADDR_LO: begin
                sum_d   = sum_q + byte_c;
                addr_d  = {addr_q[15:8], byte_c};
                phase_d = PH_BODY;
              end
              default: begin
                if (left_q <= 8'd1) begin
                  // checksum byte
                  if (chk_en_q && byte_c != ~sum_q) begin
                    fail_c    = 1'b1;
                    fail_code = ERR_SUM;
                  end else begin
                    phase_d = PH_TAIL;
                  end
                  left_d = '0;
                end else begin
                  sum_d  = sum_q + byte_c;
                  left_d = left_q - 8'd1;
                  if (rtype_q == RT_S1) begin
                    emit_c  = 1'b1;
                    kind_c  = KIND_WRITE;
                    oaddr_c = addr_q;
                    odata_c = byte_c;
                    addr_d  = addr_q + 16'd1;
                  end
                end
              end
            endcase
          end
        end
      endcase
      if (fail_c) begin
        // first error wins, skip to end of line
        if (err_q == ERR_NONE) begin
          err_d = fail_code;
        end
        phase_d = PH_SKIP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      rtype_q     <= RT_S0;
      err_q       <= ERR_NONE;
      high_q      <= '0;
      pend_q      <= 1'b0;
      left_q      <= '0;
      addr_q      <= '0;
      sum_q       <= '0;
      chk_en_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        chk_en_q <= cfg_wdata_i;
      end
      if (pop_o) begin
        phase_q <= phase_d;
        rtype_q <= rtype_d;
        err_q   <= err_d;
        high_q  <= high_d;
        pend_q  <= pend_d;
        left_q  <= left_d;
        addr_q  <= addr_d;
        sum_q   <= sum_d;
      end
      if (pop_o && emit_c) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit_c) begin
      out_kind_q <= kind_c;
      out_addr_q <= oaddr_c;
      out_data_q <= odata_c;
      out_err_q  <= oerr_c;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tdata_o  = {5'd0, out_err_q, out_data_q, out_addr_q};

endmodule

>>> rtl/core/srl_checker.sv
// Port-level checks for the S-record loader, bound to the top level.
module srl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);
  import srl_pkg::*;

  // hold a stalled result request
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  a_write_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_WRITE |->
      m_axis_tdata_o[31:24] == 8'd0)
    else $error("write carries an error code");

  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_START |->
      m_axis_tdata_o[31:16] == 16'd0)
    else $error("start address carries data or error");

  a_ok_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_OK |-> m_axis_tdata_o == 32'd0)
    else $error("record ok with nonzero payload");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_ERROR |->
      m_axis_tdata_o[23:0] == 24'd0 &&
      (m_axis_tdata_o[26:24] == ERR_NOT_S || m_axis_tdata_o[26:24] == ERR_TYPE ||
       m_axis_tdata_o[26:24] == ERR_SUM || m_axis_tdata_o[26:24] == ERR_HEX) &&
      m_axis_tdata_o[31:27] == 5'd0)
    else $error("record error with bad payload");

endmodule

bind srecord_loader_unit srl_checker u_srl_checker (.*);

>>> sim/srecord_loader_unit_tb.sv
// Testbench for the S-record loader: directed and random record text checked against a predictor.
`timescale 1ns / 100ps

module srecord_loader_unit_tb;
  import srl_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 6;

  typedef struct {
    srl_kind_e  kind;
    logic [15:0] addr;
    logic [7:0]  data;
    srl_err_e    err;
  } load_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  // Loader state as tracked by the testbench.
  srl_phase_e  ld_phase;
  logic [3:0]  ld_hi_nib;
  logic        ld_nib_pend;
  logic [7:0]  ld_left;
  logic [15:0] ld_addr;
  logic [7:0]  ld_sum;
  srl_rtype_e  ld_rtype;
  srl_err_e    ld_err;
  logic        ld_sum_check;

  load_result_t load_results_q[$];
  logic [7:0]   line_buf[$];

  int fail_count = 0;
  int sent_chars = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  int cfg_writes = 0;
  int kind_count[4];
  int err_count[5];
  bit steady = 1'b0;

  load_result_t want;
  logic [1:0]   got_kind;
  logic [15:0]  got_addr;
  logic [7:0]   got_data;
  logic [2:0]   got_err;

  srecord_loader_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int hex_value(input logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
    if (c >= CHAR_UC_A && c <= CHAR_UC_F) return int'(c - CHAR_UC_A) + 10;
    if (c >= CHAR_LC_A && c <= CHAR_LC_F) return int'(c - CHAR_LC_A) + 10;
    return -1;
  endfunction

  task automatic expect_result(input srl_kind_e k, input logic [15:0] a, input logic [7:0] d,
                               input srl_err_e e);
    load_result_t r;
    r.kind = k;
    r.addr = a;
    r.data = d;
    r.err  = e;
    load_results_q.push_back(r);
  endtask

  task automatic raise_error(input srl_err_e e);
    if (ld_err == ERR_NONE) ld_err = e;
    ld_phase = PH_SKIP;
  endtask

  task automatic clear_record();
    ld_phase    = PH_WAIT;
    ld_hi_nib   = '0;
    ld_nib_pend = 1'b0;
    ld_left     = '0;
    ld_sum      = '0;
    ld_err      = ERR_NONE;
  endtask

  task automatic reset_tracker();
    ld_sum_check = 1'b1;
    clear_record();
    ld_addr  = '0;
    ld_rtype = RT_S0;
  endtask

  task automatic take_byte(input logic [7:0] b);
    case (ld_phase)
      PH_COUNT: begin
        if (b < MIN_COUNT) begin
          raise_error(ERR_HEX);
        end else begin
          ld_sum   = b;
          ld_left  = b - 8'd2;
          ld_phase = PH_ADDR_HI;
        end
      end
      PH_ADDR_HI: begin
        ld_sum   = ld_sum + b;
        ld_addr  = {b, 8'h00};
        ld_phase = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        ld_sum       = ld_sum + b;
        ld_addr[7:0] = b;
        ld_phase     = PH_BODY;
      end
      default: begin
        if (ld_left <= 8'd1) begin
          if (ld_sum_check && b != ~ld_sum) raise_error(ERR_SUM);
          else ld_phase = PH_TAIL;
          ld_left = '0;
        end else begin
          ld_sum  = ld_sum + b;
          ld_left = ld_left - 8'd1;
          if (ld_rtype == RT_S1) begin
            expect_result(KIND_WRITE, ld_addr, b, ERR_NONE);
            ld_addr = ld_addr + 16'd1;
          end
        end
      end
    endcase
  endtask

  task automatic track_srecord_char(input logic [7:0] c);
    int v;
    if (c == CHAR_LF) begin
      if (ld_phase != PH_WAIT) begin
        if (ld_phase == PH_TYPE) raise_error(ERR_TYPE);
        else if (ld_phase != PH_TAIL && ld_phase != PH_SKIP) raise_error(ERR_HEX);
        if (ld_err != ERR_NONE) expect_result(KIND_ERROR, '0, '0, ld_err);
        else if (ld_rtype == RT_S9) expect_result(KIND_START, ld_addr, '0, ERR_NONE);
        else expect_result(KIND_OK, '0, '0, ERR_NONE);
        clear_record();
      end
    end else if (c != CHAR_CR) begin
      case (ld_phase)
        PH_WAIT: begin
          if (c == CHAR_S) ld_phase = PH_TYPE;
          else raise_error(ERR_NOT_S);
        end
        PH_TYPE: begin
          if (c == CHAR_ZERO || c == CHAR_ONE || c == CHAR_NINE) begin
            if (c == CHAR_ZERO) ld_rtype = RT_S0;
            else if (c == CHAR_ONE) ld_rtype = RT_S1;
            else ld_rtype = RT_S9;
            ld_phase    = PH_COUNT;
            ld_nib_pend = 1'b0;
          end else begin
            raise_error(ERR_TYPE);
          end
        end
        PH_TAIL, PH_SKIP: ;
        default: begin
          v = hex_value(c);
          if (v < 0) begin
            raise_error(ERR_HEX);
          end else if (!ld_nib_pend) begin
            ld_hi_nib   = v[3:0];
            ld_nib_pend = 1'b1;
          end else begin
            ld_nib_pend = 1'b0;
            take_byte({ld_hi_nib, v[3:0]});
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (fail_count < 40)
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_kind = m_axis_tuser_o;
      got_addr = m_axis_tdata_o[15:0];
      got_data = m_axis_tdata_o[23:16];
      got_err  = m_axis_tdata_o[26:24];
      kind_count[got_kind]++;
      if (got_err <= 3'd4) err_count[got_err]++;
      if (load_results_q.size() == 0) begin
        report_mismatch("unexpected result kind", 32'(got_kind), '0);
      end else begin
        want = load_results_q.pop_front();
        if (got_kind !== want.kind)
          report_mismatch("kind", 32'(got_kind), 32'(want.kind));
        if (got_addr !== want.addr)
          report_mismatch("address", 32'(got_addr), 32'(want.addr));
        if (got_data !== want.data)
          report_mismatch("data", 32'(got_data), 32'(want.data));
        if (got_err !== want.err)
          report_mismatch("error_code", 32'(got_err), 32'(want.err));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: long hold-off first, then random stalls unless streaming steadily.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else if (steady) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= 28);
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_char(input logic [7:0] c);
    @(negedge clk_i);
    if (!steady && $urandom_range(99) < 28) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(2, 1)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    do @(posedge clk_i); while (!s_axis_tready_o);
    track_srecord_char(c);
    if (c != CHAR_CR) sent_chars++;
  endtask

  task automatic send_line();
    line_buf.push_back(CHAR_LF);
    foreach (line_buf[i]) send_char(line_buf[i]);
    line_buf.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return CHAR_ZERO + 8'(n);
    return (lower ? CHAR_LC_A : CHAR_UC_A) + 8'(n - 4'd10);
  endfunction

  task automatic add_hex_byte(input logic [7:0] b);
    line_buf.push_back(hex_char(b[7:4], 1'($urandom_range(1))));
    line_buf.push_back(hex_char(b[3:0], 1'($urandom_range(1))));
  endtask

  task automatic build_record(input logic [7:0] type_ch, input int n_data,
                              input logic [15:0] addr, input bit sum_ok);
    logic [7:0] cnt;
    logic [7:0] sum;
    logic [7:0] d;
    cnt = 8'(n_data + 3);
    sum = cnt + addr[15:8] + addr[7:0];
    line_buf.push_back(CHAR_S);
    line_buf.push_back(type_ch);
    add_hex_byte(cnt);
    add_hex_byte(addr[15:8]);
    add_hex_byte(addr[7:0]);
    for (int i = 0; i < n_data; i++) begin
      d   = 8'($urandom_range(255));
      sum = sum + d;
      add_hex_byte(d);
    end
    add_hex_byte(sum_ok ? ~sum : ~sum ^ 8'($urandom_range(255, 1)));
  endtask

  // Lower valid and wait until every expected result is out and the pipe is empty.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (load_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_checksum_check(input bit on);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= on;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    ld_sum_check = on;
    cfg_writes++;
  endtask

  task automatic queue_random_line();
    int r;
    int n;
    int mode;
    logic [7:0] type_ch;
    logic [15:0] addr;
    r = $urandom_range(99);
    if (r < 92) begin
      mode = $urandom_range(99);
      if (mode < 60) type_ch = CHAR_ONE;
      else if (mode < 80) type_ch = CHAR_ZERO;
      else type_ch = CHAR_NINE;
      // Mostly short records; now and then a long one.
      if ($urandom_range(59) == 0) n = $urandom_range(252, 200);
      else n = $urandom_range(8);
      if (type_ch == CHAR_NINE && $urandom_range(1)) n = 0;
      addr = ($urandom_range(3) == 0) ? 16'hFFFF - 16'($urandom_range(8))
                                      : 16'($urandom_range(16'hFFFF));
      build_record(type_ch, n, addr, $urandom_range(99) >= 15);
      if ($urandom_range(9) == 0) add_text("zz 1");
      if (r >= 80) begin
        // Break the record: cut it short or overwrite one character.
        if ($urandom_range(1)) begin
          n = $urandom_range(line_buf.size() - 1);
          while (line_buf.size() > n) void'(line_buf.pop_back());
        end else begin
          line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
        end
      end
      if ($urandom_range(3) == 0) line_buf.push_back(CHAR_CR);
    end else begin
      if ($urandom_range(1)) line_buf.push_back(CHAR_S);
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++) line_buf.push_back(8'($urandom_range(255)));
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_lines();
    send_line();                              // blank line
    add_text("S105FFFF00FFFD");               // two writes wrapping past FFFF
    line_buf.push_back(CHAR_CR);
    send_line();
    add_text("S9031234B6"); send_line();
    add_text("S9030000FC"); send_line();
    line_buf.push_back(8'hFF); send_line();   // not an S
    add_text("s1"); send_line();
    add_text("S5"); send_line();              // unsupported type
    add_text("S"); send_line();               // ends before the type digit
    add_text("S1"); line_buf.push_back(8'h00); send_line();
    add_text("S1G0"); send_line();
    add_text("S10200"); send_line();          // count too small
    add_text("S1050010"); send_line();        // ends early
    add_text("S1040010abcd"); send_line();    // checksum mismatch after a write
    add_text("S1040010ab40zz!"); send_line(); // trailing text
    build_record(CHAR_ZERO, 3, 16'h0000, 1'b1); send_line();
    set_checksum_check(1'b0);
    add_text("S1040010abcd"); send_line();
    set_checksum_check(1'b1);
  endtask

  task automatic test_backpressure();
    drain();
    steady = 1'b1;
    @(posedge clk_i);
    hold_left = 80;
    build_record(CHAR_ONE, 40, 16'($urandom_range(16'hFFFF)), 1'b1);
    send_line();
    steady = 1'b0;
    drain();
  endtask

  task automatic test_random_records(input int n_chars);
    int start;
    start = sent_chars;
    while (sent_chars - start < n_chars) begin
      queue_random_line();
      send_line();
    end
  endtask

  task automatic test_steady_stream(input int n_chars);
    drain();
    steady = 1'b1;
    test_random_records(n_chars);
    steady = 1'b0;
  endtask

  initial begin
    reset_tracker();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_lines();
    test_backpressure();
    test_random_records(500);
    set_checksum_check(1'b0);
    test_random_records(400);
    set_checksum_check(1'b1);
    test_steady_stream(300);
    set_checksum_check(1'b0);
    test_random_records(250);
    set_checksum_check(1'b1);
    test_random_records(350);

    drain();
    repeat (10) @(posedge clk_i);
    if (load_results_q.size() != 0) report_mismatch("results never delivered",
                                                    32'(load_results_q.size()), '0);
    $display("Sent %0d characters; results: %0d writes, %0d start, %0d ok, %0d failed",
             sent_chars, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
    $display("Failures by cause: not S %0d, type %0d, checksum %0d, hex %0d; %0d cfg writes",
             err_count[1], err_count[2], err_count[3], err_count[4], cfg_writes);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/srl_pkg.sv
rtl/core/srl_front.sv
rtl/core/srl_queue.sv
rtl/core/srl_exec.sv
rtl/core/srecord_loader_unit.sv
rtl/core/srl_checker.sv
sim/srecord_loader_unit_tb.sv
